>>> hdl/two_stacks_shared_memory_core_macros.svh
// assertion macros for the two-stack core
// expects clk and arst_n in the scope of use
`ifndef TWO_STACKS_SHARED_MEMORY_CORE_MACROS_SVH
`define TWO_STACKS_SHARED_MEMORY_CORE_MACROS_SVH

// property must hold at every edge outside reset
`define TSS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// condition must never be seen outside reset
`define TSS_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

>>> hdl/tss_pkg.sv
// shared types, codes and helpers of the two-stack core
// no dependencies
package tss_pkg;

	localparam int unsigned DEPTH_DEF = 16;
	localparam int unsigned CNT_W     = 5;
	localparam int unsigned DATA_W    = 32;
	localparam logic [CNT_W-1:0] CAP_RESET = 5'd16;

	typedef logic signed [DATA_W-1:0] word_t;
	typedef logic [CNT_W-1:0]         cnt_t;

	localparam word_t WORD_EMPTY = -32'sd1;

	// request codes
	localparam logic [1:0] MODE_PUSH = 2'd0;
	localparam logic [1:0] MODE_POP  = 2'd1;
	localparam logic [1:0] MODE_PEEK = 2'd2;

	// result status codes
	localparam logic [1:0] STAT_OK        = 2'd0;
	localparam logic [1:0] STAT_OVERFLOW  = 2'd1;
	localparam logic [1:0] STAT_UNDERFLOW = 2'd2;

	typedef enum logic [0:0] {
		CTRL_IDLE,
		CTRL_EXEC
	} ctrl_state_t;

	// controller to datapath commands
	typedef struct packed {
		logic load;    // capture request, issue memory read
		logic commit;  // update pointers, write memory, load result
	} tss_cmd_t;

	// capacity clamped to 1..depth
	function automatic cnt_t sat_cap(input cnt_t raw, input int unsigned depth);
		cnt_t c;
		c = raw;
		if (c == '0) c = CNT_W'(1);
		if (32'(c) > depth) c = CNT_W'(depth);
		return c;
	endfunction

endpackage

>>> hdl/tss_if.sv
// request and result channel interfaces of the two-stack core
// depends on tss_pkg
interface tss_req_if;
	import tss_pkg::*;
	logic       valid;
	logic       ready;
	logic [1:0] mode;
	logic       which_stack;
	word_t      push_value;
	modport source (output valid, mode, which_stack, push_value, input ready);
	modport sink (input valid, mode, which_stack, push_value, output ready);
endinterface

interface tss_rsp_if;
	import tss_pkg::*;
	logic       valid;
	logic       ready;
	logic [1:0] status;
	word_t      read_value;
	cnt_t       count_lower;
	cnt_t       count_upper;
	modport source (output valid, status, read_value, count_lower, count_upper, input ready);
	modport sink (input valid, status, read_value, count_lower, count_upper, output ready);
endinterface

>>> hdl/two_stacks_shared_memory_core.sv
// two stacks in one memory: a request beat starts the memory read, then commits to the result register
// one request in flight: no new request is taken until the previous one has committed
// a new request is taken while the previous result still waits in its register
// reset: both stacks empty, capacity 16 clamped to 1..DEPTH; memory not cleared
`include "two_stacks_shared_memory_core_macros.svh"
module two_stacks_shared_memory_core #(
	parameter int unsigned DEPTH = tss_pkg::DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	tss_req_if.sink       req,
	tss_rsp_if.source     rsp,
	input  logic          cap_we,
	input  tss_pkg::cnt_t cap_wdata
);
	import tss_pkg::*;

	tss_cmd_t cmd;

	// controller: one request in flight, commit when result register is free or emptying
	tss_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.cmd       (cmd)
	);

	// datapath: load reads the memory, commit acts on the read data
	tss_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.cap_we      (cap_we),
		.cap_wdata   (cap_wdata),
		.mode        (req.mode),
		.which_stack (req.which_stack),
		.push_value  (req.push_value),
		.status      (rsp.status),
		.read_value  (rsp.read_value),
		.count_lower (rsp.count_lower),
		.count_upper (rsp.count_upper)
	);

	// the cycle after a request beat the block is busy
	`TSS_ASSERT(a_one_in_flight, (req.valid && req.ready) |=> !req.ready, "request taken while busy")
	// an underflow result always carries the empty marker
	`TSS_ASSERT(a_underflow_value, (rsp.valid && rsp.status == STAT_UNDERFLOW) |-> (rsp.read_value == WORD_EMPTY), "underflow without empty marker")
	// a failed push never returns data
	`TSS_NEVER(a_overflow_value, rsp.valid && rsp.status == STAT_OVERFLOW && rsp.read_value != '0, "overflow with nonzero data")

endmodule

>>> hdl/tss_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module tss_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 16,
	parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
	end

	always_ff @(posedge clk) begin
		if (re) rdata <= mem[raddr];
	end

endmodule

>>> hdl/tss_ctrl.sv
// controller state machine of the two-stack core
// depends on tss_pkg
module tss_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output tss_pkg::tss_cmd_t cmd
);
	import tss_pkg::*;

	ctrl_state_t state_q, state_d;
	logic        out_valid_q, out_valid_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= CTRL_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_ready = (state_q == CTRL_IDLE);
		case (state_q)
			CTRL_IDLE: begin
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = CTRL_EXEC;
				end
			end
			CTRL_EXEC: begin
				// result register must be free or emptying this cycle
				if (!out_valid_q || rsp_ready) begin
					cmd.commit = 1'b1;
					state_d    = CTRL_IDLE;
				end
			end
			default: state_d = CTRL_IDLE;
		endcase
		if (cmd.commit) out_valid_d = 1'b1;
		else if (rsp_ready) out_valid_d = 1'b0;
		else out_valid_d = out_valid_q;
	end

	assign rsp_valid = out_valid_q;

endmodule

>>> hdl/tss_dp.sv
// datapath of the two-stack core: pointers, shared memory, result register
// depends on tss_pkg and tss_ram
module tss_dp #(
	parameter int unsigned DEPTH = tss_pkg::DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  tss_pkg::tss_cmd_t cmd,
	input  logic              cap_we,
	input  tss_pkg::cnt_t     cap_wdata,
	input  logic [1:0]        mode,
	input  logic              which_stack,
	input  tss_pkg::word_t    push_value,
	output logic [1:0]        status,
	output tss_pkg::word_t    read_value,
	output tss_pkg::cnt_t     count_lower,
	output tss_pkg::cnt_t     count_upper
);
	import tss_pkg::*;

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	cnt_t       cap_q, lower_q, upper_q;
	cnt_t       lower_d, upper_d, wptr;
	logic [1:0] mode_s1;
	logic       which_s1;
	word_t      value_s1;
	logic [DATA_W-1:0] rdata;
	logic       we;
	logic       empty;
	logic [1:0] stat_d;
	word_t      rd_d;
	cnt_t       rptr;

	// read address comes from the incoming beat and current pointers
	assign rptr = which_stack ? upper_q : (lower_q - CNT_W'(1));

	tss_ram #(
		.WIDTH (DATA_W),
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (cmd.commit && we),
		.waddr (AW'(wptr)),
		.wdata (value_s1),
		.re    (cmd.load),
		.raddr (AW'(rptr)),
		.rdata (rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_s1  <= mode;
			which_s1 <= which_stack;
			value_s1 <= push_value;
		end
	end

	always_comb begin
		stat_d  = STAT_OK;
		rd_d    = '0;
		lower_d = lower_q;
		upper_d = upper_q;
		we      = 1'b0;
		wptr    = lower_q;
		empty   = which_s1 ? (upper_q >= cap_q) : (lower_q == '0);
		case (mode_s1)
			MODE_PUSH: begin
				if (lower_q >= upper_q) begin
					stat_d = STAT_OVERFLOW;
				end else if (!which_s1) begin
					we      = 1'b1;
					wptr    = lower_q;
					lower_d = lower_q + CNT_W'(1);
				end else begin
					we      = 1'b1;
					wptr    = upper_q - CNT_W'(1);
					upper_d = upper_q - CNT_W'(1);
				end
			end
			MODE_POP, MODE_PEEK: begin
				if (empty) begin
					stat_d = STAT_UNDERFLOW;
					rd_d   = WORD_EMPTY;
				end else begin
					rd_d = word_t'(rdata);
					if (mode_s1 == MODE_POP) begin
						if (!which_s1) lower_d = lower_q - CNT_W'(1);
						else upper_d = upper_q + CNT_W'(1);
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q   <= sat_cap(CAP_RESET, DEPTH);
			lower_q <= '0;
			upper_q <= sat_cap(CAP_RESET, DEPTH);
		end else if (cap_we) begin
			cap_q   <= sat_cap(cap_wdata, DEPTH);
			lower_q <= '0;
			upper_q <= sat_cap(cap_wdata, DEPTH);
		end else if (cmd.commit) begin
			lower_q <= lower_d;
			upper_q <= upper_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			status      <= stat_d;
			read_value  <= rd_d;
			count_lower <= lower_d;
			count_upper <= cap_q - upper_d;
		end
	end

endmodule

>>> tb/sv/two_stacks_shared_memory_core_tb.sv
// self-checking testbench of the two-stack core: directed and random request beats
// depends on tss_pkg, tss_if and the core itself; predicts every result beat
module two_stacks_shared_memory_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import tss_pkg::*;

	localparam int unsigned CLK_PERIOD      = 10;
	localparam int unsigned STORE_DEPTH     = DEPTH_DEF;
	// quiet cycles tolerated by the watchdog; well above the long receiver hold
	localparam int unsigned QUIET_LIMIT     = 4000;
	localparam int unsigned RSP_HOLD_CYCLES = 400;
	// let the core settle before touching the register
	localparam int unsigned SETTLE_CYCLES   = 4;
	localparam int unsigned SHOWN_LIMIT     = 10;
	localparam int unsigned SEGMENTS        = 5;
	localparam int unsigned SEGMENT_BEATS   = 100;

	// the fourth request code has no meaning and must leave the stacks alone
	localparam logic [1:0] MODE_UNUSED = 2'd3;
	localparam logic       STACK_LOWER = 1'b0;
	localparam logic       STACK_UPPER = 1'b1;

	typedef struct packed {
		logic [1:0] status;
		word_t      value;
		cnt_t       lower;
		cnt_t       upper;
	} stack_result_t;

	// shadow of both stacks plus the queue of result beats still owed by the core
	class stack_pair_scoreboard;
		word_t         shadow_mem [STORE_DEPTH];
		int unsigned   lower_cnt;
		int unsigned   upper_base;
		int unsigned   cap_eff;
		stack_result_t owed_results [$];
		int unsigned   mismatches;

		function new();
			mismatches = 0;
			set_capacity(CAP_RESET);
		endfunction

		// register write: clamp to 1..depth and empty both stacks
		function void set_capacity(input cnt_t raw);
			if (raw == '0)
				cap_eff = 1;
			else if (int'(raw) > STORE_DEPTH)
				cap_eff = STORE_DEPTH;
			else
				cap_eff = 32'(raw);
			lower_cnt = 0;
			upper_base = cap_eff;
		endfunction

		// accepted request beat: update the shadow and queue its result
		function void note_request(input logic [1:0] mode, input logic stk, input word_t val);
			stack_result_t r;
			bit            is_empty;
			r.status = STAT_OK;
			r.value = '0;
			case (mode)
				MODE_PUSH: begin
					if (lower_cnt >= upper_base) begin
						r.status = STAT_OVERFLOW;
					end else if (stk == STACK_LOWER) begin
						shadow_mem[lower_cnt] = val;
						lower_cnt++;
					end else begin
						upper_base--;
						shadow_mem[upper_base] = val;
					end
				end
				MODE_POP, MODE_PEEK: begin
					is_empty = (stk == STACK_LOWER) ? (lower_cnt == 0) : (upper_base >= cap_eff);
					if (is_empty) begin
						r.status = STAT_UNDERFLOW;
						r.value = WORD_EMPTY;
					end else if (stk == STACK_LOWER) begin
						r.value = shadow_mem[lower_cnt - 1];
						if (mode == MODE_POP) lower_cnt--;
					end else begin
						r.value = shadow_mem[upper_base];
						if (mode == MODE_POP) upper_base++;
					end
				end
				default: ;
			endcase
			r.lower = cnt_t'(lower_cnt);
			r.upper = cnt_t'(cap_eff - upper_base);
			owed_results.push_back(r);
		endfunction

		// accepted result beat: compare with the oldest owed result
		function void check_result(input stack_result_t got);
			stack_result_t want;
			if (owed_results.size() == 0) begin
				mismatches++;
				if (mismatches <= SHOWN_LIMIT)
					$display("%0t: unexpected result: status %0d value %0d lower %0d upper %0d",
						$realtime, got.status, got.value, got.lower, got.upper);
				return;
			end
			want = owed_results.pop_front();
			if (got.status !== want.status || got.value !== want.value ||
					got.lower !== want.lower || got.upper !== want.upper) begin
				mismatches++;
				if (mismatches <= SHOWN_LIMIT) begin
					$write("%0t: result mismatch: want status %0d value %0d lower %0d upper %0d",
						$realtime, want.status, want.value, want.lower, want.upper);
					$display(", got status %0d value %0d lower %0d upper %0d",
						got.status, got.value, got.lower, got.upper);
				end
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic cap_we;
	cnt_t cap_wdata;

	tss_req_if req_ch();
	tss_rsp_if rsp_ch();

	stack_pair_scoreboard sb;

	// idle percentages for both sides, changed per stimulus phase
	int unsigned req_idle_pct = 0;
	int unsigned rsp_idle_pct = 0;
	// one-shot request for a long receiver hold
	bit          rsp_hold_request = 1'b0;

	two_stacks_shared_memory_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch),
		.rsp       (rsp_ch),
		.cap_we    (cap_we),
		.cap_wdata (cap_wdata)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// beat monitor: values read right after the edge are the ones the core sampled;
	// the result is checked before the new request is noted, since a result is never
	// caused by a request taken at the same edge
	always @(posedge clk) begin : beat_monitor
		stack_result_t seen;
		if (arst_n === 1'b1) begin
			if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
				seen.status = rsp_ch.status;
				seen.value = rsp_ch.read_value;
				seen.lower = rsp_ch.count_lower;
				seen.upper = rsp_ch.count_upper;
				sb.check_result(seen);
			end
			if (req_ch.valid === 1'b1 && req_ch.ready === 1'b1)
				sb.note_request(req_ch.mode, req_ch.which_stack, req_ch.push_value);
		end
	end

	// result sink: random backpressure, plus a long hold on request so the core
	// fills up and has to stall its request side
	initial begin : result_sink
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (rsp_hold_request) begin
				rsp_hold_request = 1'b0;
				rsp_ch.ready <= 1'b0;
				repeat (RSP_HOLD_CYCLES) @(posedge clk);
			end
			rsp_ch.ready <= ($urandom_range(99) >= rsp_idle_pct);
		end
	end

	// watchdog: ends the run once nothing has moved on either channel for too long
	initial begin : watchdog
		int unsigned quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
					(rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1))
				quiet = 0;
			else
				quiet++;
		end
		$display("simulation failed");
		$finish;
	end

	// offer one request beat and return at the edge that takes it; valid stays
	// high for a back-to-back beat and only drops for idle cycles
	task automatic send_req(input logic [1:0] mode, input logic stk, input word_t val);
		while ($urandom_range(99) < req_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.mode <= mode;
		req_ch.which_stack <= stk;
		req_ch.push_value <= val;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
	endtask

	// stop offering and wait until every owed result beat has come back
	task automatic drain_results();
		req_ch.valid <= 1'b0;
		do @(posedge clk); while (sb.owed_results.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// register write only on an idle core; both stacks come out empty
	task automatic write_capacity(input cnt_t raw);
		drain_results();
		cap_we <= 1'b1;
		cap_wdata <= raw;
		@(posedge clk);
		cap_we <= 1'b0;
		sb.set_capacity(raw);
		@(posedge clk);
	endtask

	// request mix: push share set by the caller, the rest mostly pop and peek
	function automatic logic [1:0] random_mode(input int unsigned push_pct);
		int unsigned r;
		if ($urandom_range(99) < push_pct) return MODE_PUSH;
		r = $urandom_range(19);
		if (r < 11) return MODE_POP;
		if (r < 18) return MODE_PEEK;
		return MODE_UNUSED;
	endfunction

	// mostly random words, now and then the extremes
	function automatic word_t random_word();
		case ($urandom_range(15))
			0: return 32'sh7fff_ffff;
			1: return 32'sh8000_0000;
			2: return '0;
			3: return WORD_EMPTY;
			default: return word_t'($urandom);
		endcase
	endfunction

	initial begin : stimulus
		cnt_t seg_cap [SEGMENTS];
		int   push_pct;
		sb = new();
		arst_n <= 1'b0;
		cap_we <= 1'b0;
		cap_wdata <= '0;
		req_ch.valid <= 1'b0;
		req_ch.mode <= MODE_PUSH;
		req_ch.which_stack <= STACK_LOWER;
		req_ch.push_value <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// after reset: capacity 16, both stacks empty
		send_req(MODE_POP, STACK_LOWER, 32'sd17);
		send_req(MODE_PEEK, STACK_UPPER, 32'sd0);
		send_req(MODE_POP, STACK_UPPER, 32'sd0);
		send_req(MODE_UNUSED, STACK_LOWER, 32'sd99);
		send_req(MODE_PUSH, STACK_LOWER, 32'sh7fff_ffff);
		send_req(MODE_PUSH, STACK_LOWER, 32'sh8000_0000);
		send_req(MODE_PUSH, STACK_UPPER, WORD_EMPTY);
		send_req(MODE_PUSH, STACK_UPPER, 32'sd0);
		send_req(MODE_PEEK, STACK_LOWER, 32'sd0);
		send_req(MODE_PEEK, STACK_UPPER, 32'sd0);
		send_req(MODE_POP, STACK_LOWER, 32'sd0);
		send_req(MODE_POP, STACK_LOWER, 32'sd0);
		send_req(MODE_POP, STACK_LOWER, 32'sd0);
		send_req(MODE_POP, STACK_UPPER, 32'sd0);
		send_req(MODE_POP, STACK_UPPER, 32'sd0);

		// single entry: one push fills the whole capacity, both sides overflow
		write_capacity(5'd1);
		send_req(MODE_PUSH, STACK_UPPER, 32'sh5a5a_5a5a);
		send_req(MODE_PUSH, STACK_LOWER, 32'sd1);
		send_req(MODE_PUSH, STACK_UPPER, 32'sd2);
		send_req(MODE_PEEK, STACK_UPPER, 32'sd0);
		send_req(MODE_POP, STACK_UPPER, 32'sd0);

		// zero clamps to one entry
		write_capacity(5'd0);
		send_req(MODE_PUSH, STACK_LOWER, 32'sha5a5_a5a5);
		send_req(MODE_PUSH, STACK_UPPER, 32'sd3);

		// above the memory size clamps to 16; the write also drops the held entry
		write_capacity(5'd31);
		send_req(MODE_POP, STACK_LOWER, 32'sd0);
		send_req(MODE_PUSH, STACK_UPPER, 32'sh1234_5678);
		send_req(MODE_UNUSED, STACK_UPPER, 32'sd0);

		// random phases: alternating fill and drain stretches so both stacks
		// meet and run dry under several capacities
		seg_cap[0] = 5'd2;
		seg_cap[1] = 5'd16;
		seg_cap[2] = cnt_t'($urandom_range(3, 15));
		seg_cap[3] = 5'd31;
		seg_cap[4] = cnt_t'($urandom_range(1, 16));
		for (int seg = 0; seg < SEGMENTS; seg++) begin
			write_capacity(seg_cap[seg]);
			if (seg < 2) begin
				req_idle_pct = 23;
				rsp_idle_pct = 67;
			end else if (seg < 4) begin
				req_idle_pct = 67;
				rsp_idle_pct = 23;
			end else begin
				req_idle_pct = 0;
				rsp_idle_pct = 0;
			end
			for (int n = 0; n < SEGMENT_BEATS; n++) begin
				// long receiver hold while requests keep coming
				if (seg == SEGMENTS - 1 && n == 20) rsp_hold_request = 1'b1;
				push_pct = ((n / 25) % 2 == 0) ? 70 : 30;
				send_req(random_mode(push_pct), 1'($urandom_range(1)), random_word());
			end
		end

		drain_results();
		if (sb.mismatches == 0 && sb.owed_results.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
